// ----- src/mcit_pkg.sv -----
// shared constants and types for the interval timer bank
`default_nettype none

package mcit_pkg;

    localparam int NUM_TIMERS     = 4;
    localparam int REG_W          = 16;
    localparam int REGS_PER_TIMER = 3;
    localparam int REG_COUNT      = NUM_TIMERS * REGS_PER_TIMER;
    localparam int ADDR_W         = $clog2(REG_COUNT);
    localparam int TMR_W          = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int OP_W           = 2;

    localparam int OFS_PRESCALE   = 0;
    localparam int OFS_COUNT      = 1;
    localparam int OFS_VECTOR     = 2;

    typedef enum logic [OP_W-1:0] {
        OP_TICK  = 2'd0,
        OP_READ  = 2'd1,
        OP_WRITE = 2'd2
    } op_t;

    typedef enum logic {
        KIND_READ = 1'b0,
        KIND_IRQ  = 1'b1
    } kind_t;

    typedef struct packed {
        logic                                is_read;
        logic [NUM_TIMERS-1:0]               fire;
        logic [REG_W-1:0]                    rd_data;
        logic [NUM_TIMERS-1:0][REG_W-1:0]    vec;
    } bank_result_t;

endpackage

`default_nettype wire

// ----- src/mcit_timer_bank.sv -----
// register file, prescale and period counters of all timers
`default_nettype none

module mcit_timer_bank (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         exec,
    input  wire logic [mcit_pkg::OP_W-1:0]    op,
    input  wire logic [mcit_pkg::ADDR_W-1:0]  addr,
    input  wire logic [mcit_pkg::REG_W-1:0]   data,
    output mcit_pkg::bank_result_t            res
);
    import mcit_pkg::*;

    logic [REG_W-1:0]      regs_reg  [REG_COUNT];
    logic [REG_W-1:0]      regs_next [REG_COUNT];
    logic [REG_W-1:0]      psc_reg   [NUM_TIMERS];
    logic [REG_W-1:0]      psc_next  [NUM_TIMERS];
    logic [REG_W-1:0]      per_reg   [NUM_TIMERS];
    logic [REG_W-1:0]      per_next  [NUM_TIMERS];
    logic [NUM_TIMERS-1:0] running;
    logic [NUM_TIMERS-1:0] fire;
    logic [REG_W-1:0]      psc_inc   [NUM_TIMERS];
    logic [REG_W-1:0]      per_inc   [NUM_TIMERS];
    logic                  is_tick;
    logic                  is_read;
    logic                  is_write;

    always_comb
    begin
        is_tick  = 1'b0;
        is_read  = 1'b0;
        is_write = 1'b0;
        case (op_t'(op))
            OP_TICK:  is_tick  = 1'b1;
            OP_READ:  is_read  = 1'b1;
            OP_WRITE: is_write = 1'b1;
            default:  ;
        endcase
    end

    always_comb
    begin
        regs_next = regs_reg;
        psc_next  = psc_reg;
        per_next  = per_reg;
        fire      = '0;
        for (int t = 0; t < NUM_TIMERS; t++)
        begin
            running[t] = (regs_reg[t*REGS_PER_TIMER + OFS_PRESCALE] != '0)
                      && (regs_reg[t*REGS_PER_TIMER + OFS_COUNT] != '0)
                      && (regs_reg[t*REGS_PER_TIMER + OFS_VECTOR] != '0);
            psc_inc[t] = psc_reg[t] + 1'b1;
            per_inc[t] = per_reg[t] + 1'b1;
            if (exec && is_tick)
            begin
                if (!running[t])
                begin
                    psc_next[t] = '0;
                    per_next[t] = '0;
                end
                else if (psc_inc[t] >= regs_reg[t*REGS_PER_TIMER + OFS_PRESCALE])
                begin
                    psc_next[t] = '0;
                    if (per_inc[t] >= regs_reg[t*REGS_PER_TIMER + OFS_COUNT])
                    begin
                        per_next[t] = '0;
                        fire[t]     = 1'b1;
                    end
                    else
                    begin
                        per_next[t] = per_inc[t];
                    end
                end
                else
                begin
                    psc_next[t] = psc_inc[t];
                end
            end
            // a write restarts the whole period of its timer
            for (int o = 0; o < REGS_PER_TIMER; o++)
            begin
                if (exec && is_write && (addr == ADDR_W'(t*REGS_PER_TIMER + o)))
                begin
                    regs_next[t*REGS_PER_TIMER + o] = data;
                    psc_next[t] = '0;
                    per_next[t] = '0;
                end
            end
        end
    end

    always_comb
    begin
        res         = '0;
        res.is_read = is_read;
        res.fire    = fire;
        if (is_read && (addr < ADDR_W'(REG_COUNT)))
        begin
            res.rd_data = regs_reg[addr];
        end
        for (int t = 0; t < NUM_TIMERS; t++)
        begin
            res.vec[t] = regs_reg[t*REGS_PER_TIMER + OFS_VECTOR];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < REG_COUNT; r++)
            begin
                regs_reg[r] <= '0;
            end
            for (int t = 0; t < NUM_TIMERS; t++)
            begin
                psc_reg[t] <= '0;
                per_reg[t] <= '0;
            end
        end
        else
        begin
            regs_reg <= regs_next;
            psc_reg  <= psc_next;
            per_reg  <= per_next;
        end
    end

    for (genvar g = 0; g < NUM_TIMERS; g++)
    begin : g_chk
        // a stopped timer sits at zero
        a_stopped_idle: assert property (@(posedge clk) disable iff (!rst_n)
            !running[g] |-> (psc_reg[g] == '0) && (per_reg[g] == '0))
            else $error("stopped timer has nonzero counters");

        // counters stay below their limits while running
        a_running_bounds: assert property (@(posedge clk) disable iff (!rst_n)
            running[g] |->
                (psc_reg[g] < regs_reg[g*REGS_PER_TIMER + OFS_PRESCALE]) &&
                (per_reg[g] < regs_reg[g*REGS_PER_TIMER + OFS_COUNT]))
            else $error("timer counter past its limit");
    end

endmodule

`default_nettype wire

// ----- src/mcit_result_queue.sv -----
// holds the results of one request and hands them out one per cycle while out_stall is low
`default_nettype none

module mcit_result_queue (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         exec,
    input  wire mcit_pkg::bank_result_t       res,
    output logic                              can_load,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic                              result_kind,
    output logic [mcit_pkg::REG_W-1:0]        read_data,
    output logic [mcit_pkg::REG_W-1:0]        irq_vector,
    output logic [mcit_pkg::TMR_W-1:0]        firing_timer,
    output logic                              last_of_run
);
    import mcit_pkg::*;

    logic                               read_pend_reg;
    logic                               read_pend_next;
    logic [NUM_TIMERS-1:0]              fire_pend_reg;
    logic [NUM_TIMERS-1:0]              fire_pend_next;
    logic [REG_W-1:0]                   rd_reg;
    logic [NUM_TIMERS-1:0][REG_W-1:0]   vec_reg;
    logic [NUM_TIMERS-1:0]              remaining;
    logic [TMR_W-1:0]                   idx;
    logic                               take;
    logic                               load;

    // lowest pending timer goes first
    always_comb
    begin
        idx = '0;
        for (int i = NUM_TIMERS - 1; i >= 0; i--)
        begin
            if (fire_pend_reg[i])
            begin
                idx = TMR_W'(i);
            end
        end
    end

    assign remaining = fire_pend_reg & (fire_pend_reg - 1'b1);
    assign out_valid = read_pend_reg || (fire_pend_reg != '0);
    assign take      = out_valid && !out_stall;
    assign last_of_run = read_pend_reg || (remaining == '0);
    assign can_load  = !out_valid || (take && last_of_run);
    assign load      = exec && (res.is_read || (res.fire != '0));

    assign result_kind  = read_pend_reg ? KIND_READ : KIND_IRQ;
    assign read_data    = read_pend_reg ? rd_reg : '0;
    assign irq_vector   = read_pend_reg ? '0 : vec_reg[idx];
    assign firing_timer = read_pend_reg ? '0 : idx;

    always_comb
    begin
        read_pend_next = read_pend_reg;
        fire_pend_next = fire_pend_reg;
        if (take)
        begin
            if (read_pend_reg)
            begin
                read_pend_next = 1'b0;
            end
            else
            begin
                fire_pend_next = remaining;
            end
        end
        if (load)
        begin
            read_pend_next = res.is_read;
            fire_pend_next = res.fire;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            read_pend_reg <= 1'b0;
            fire_pend_reg <= '0;
        end
        else
        begin
            read_pend_reg <= read_pend_next;
            fire_pend_reg <= fire_pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rd_reg  <= res.rd_data;
            vec_reg <= res.vec;
        end
    end

    a_read_alone: assert property (@(posedge clk) disable iff (!rst_n)
        read_pend_reg |-> (fire_pend_reg == '0))
        else $error("read response mixed with interrupts");

    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (take && !last_of_run) |=> out_valid)
        else $error("result run ended early");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> can_load)
        else $error("pending results overwritten");

endmodule

`default_nettype wire

// ----- src/multi_channel_interval_timer_core.sv -----
// top level of the interval timer bank: request register, timer bank, result queue
//
//  channel   valid      stall      payload
//  request   in_valid   in_stall   operation, reg_address, write_data
//  result    out_valid  out_stall  result_kind, read_data, irq_vector,
//                                  firing_timer, last_of_run
//
// one request per cycle while in_stall is low; results are registered in the result queue
// a tick that fires k timers gives k results, one per cycle while out_stall is low;
// the next request waits in the request register meanwhile, with in_stall high
// reset clears the request valid, timer registers, counters and pending flags, asynchronous, active low
// out_stall backs up into in_stall only when the result queue cannot drain
`default_nettype none

module multi_channel_interval_timer_core (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic [mcit_pkg::OP_W-1:0]    operation,
    input  wire logic [mcit_pkg::ADDR_W-1:0]  reg_address,
    input  wire logic [mcit_pkg::REG_W-1:0]   write_data,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic                              result_kind,
    output logic [mcit_pkg::REG_W-1:0]        read_data,
    output logic [mcit_pkg::REG_W-1:0]        irq_vector,
    output logic [mcit_pkg::TMR_W-1:0]        firing_timer,
    output logic                              last_of_run
);
    import mcit_pkg::*;

    logic                in_valid_reg;
    logic [OP_W-1:0]     op_reg;
    logic [ADDR_W-1:0]   addr_reg;
    logic [REG_W-1:0]    data_reg;
    logic                can_load;
    logic                exec;
    bank_result_t        res;

    assign exec     = in_valid_reg && can_load;
    assign in_stall = in_valid_reg && !can_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            op_reg   <= operation;
            addr_reg <= reg_address;
            data_reg <= write_data;
        end
    end

    mcit_timer_bank u_bank (
        .clk   (clk),
        .rst_n (rst_n),
        .exec  (exec),
        .op    (op_reg),
        .addr  (addr_reg),
        .data  (data_reg),
        .res   (res)
    );

    mcit_result_queue u_queue (
        .clk          (clk),
        .rst_n        (rst_n),
        .exec         (exec),
        .res          (res),
        .can_load     (can_load),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .result_kind  (result_kind),
        .read_data    (read_data),
        .irq_vector   (irq_vector),
        .firing_timer (firing_timer),
        .last_of_run  (last_of_run)
    );

    a_read_answers: assert property (@(posedge clk) disable iff (!rst_n)
        (exec && (op_reg == OP_READ)) |=> out_valid && (result_kind == KIND_READ))
        else $error("read request gave no response");

endmodule

`default_nettype wire
